// ===== rtl/cls_pkg.sv =====
// Package for the color light steering block: payload structs, config types,
// state encodings and sizing constants. No dependencies.
`default_nettype none

package cls_pkg;

  // Sample width used from each 16-bit reading (range 8 to 16)
  localparam int SampleBits = 16;
  localparam int SumBits    = SampleBits + 2;  // r + g + b of one sensor
  localparam int ProdBits   = SumBits + 4;     // sensitivity * sum
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [3:0]  SensitivityReset    = 4'd5;
  localparam logic [15:0] GreenThresholdReset = 16'h3200;
  localparam logic [3:0]  HoldTicksReset      = 4'd6;
  localparam logic [3:0]  DomScale            = 4'd10;

  // Configuration register indexes
  localparam logic [1:0] CfgSensitivity    = 2'd0;
  localparam logic [1:0] CfgGreenThreshold = 2'd1;
  localparam logic [1:0] CfgHoldTicks      = 2'd2;

  // Sensor indexes
  localparam logic [1:0] SensorRight  = 2'd0;
  localparam logic [1:0] SensorCenter = 2'd1;
  localparam logic [1:0] SensorLeft   = 2'd2;

  // Output codes
  localparam logic [1:0] MotionForward = 2'd0;
  localparam logic [1:0] MotionRight   = 2'd1;
  localparam logic [1:0] MotionLeft    = 2'd2;

  localparam logic [2:0] ModeCodeDefault = 3'd0;
  localparam logic [2:0] ModeCodeRg      = 3'd1;
  localparam logic [2:0] ModeCodeLg      = 3'd2;
  localparam logic [2:0] ModeCodeLr      = 3'd3;
  localparam logic [2:0] ModeCodeRr      = 3'd4;

  typedef struct packed {
    logic [15:0] right_red;
    logic [15:0] right_green;
    logic [15:0] right_blue;
    logic [15:0] center_red;
    logic [15:0] center_green;
    logic [15:0] center_blue;
    logic [15:0] left_red;
    logic [15:0] left_green;
    logic [15:0] left_blue;
  } cls_in_t;

  typedef struct packed {
    logic [1:0] motion;
    logic [2:0] steer_mode;
    logic       indicator;
  } cls_out_t;

  typedef struct packed {
    logic [3:0]  sensitivity;
    logic [15:0] green_threshold;
    logic [3:0]  hold_ticks;
  } cls_cfg_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic [1:0]            red_idx;
    logic [1:0]            green_idx;
    logic [SampleBits-1:0] red_peak;
    logic [SampleBits-1:0] green_peak;
    logic                  red_dom;
    logic                  green_dom;
    logic                  green_all;
  } cls_class_t;

  typedef enum logic [2:0] {
    FE_IDLE  = 3'b001,
    FE_PEAK  = 3'b010,
    FE_CLASS = 3'b100
  } cls_front_state_e;

  typedef enum logic [4:0] {
    MODE_DEFAULT = 5'b00001,
    MODE_RG      = 5'b00010,
    MODE_LG      = 5'b00100,
    MODE_LR      = 5'b01000,
    MODE_RR      = 5'b10000
  } cls_mode_e;

  typedef struct packed {
    cls_mode_e             mode;
    logic [SampleBits-1:0] last_peak;
  } cls_track_t;

  function automatic logic [2:0] mode_code(cls_mode_e m);
    logic [2:0] c;
    case (m)
      MODE_RG: c = ModeCodeRg;
      MODE_LG: c = ModeCodeLg;
      MODE_LR: c = ModeCodeLr;
      MODE_RR: c = ModeCodeRr;
      default: c = ModeCodeDefault;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] motion_code(cls_mode_e m);
    logic [1:0] c;
    case (m)
      MODE_RG, MODE_RR: c = MotionRight;
      MODE_LG, MODE_LR: c = MotionLeft;
      default:          c = MotionForward;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cls_front.sv =====
// Front part: accepts a tick, finds the red and green peaks and tests dominance.
// Depends on cls_pkg.
`default_nettype none

module cls_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cls_pkg::cls_cfg_t cfg_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire cls_pkg::cls_in_t in_data_i,
  output logic                  push_o,
  output cls_pkg::cls_class_t   push_data_o,
  input  wire logic             full_i
);

  cls_pkg::cls_front_state_e state_q, state_d;

  logic [cls_pkg::SampleBits-1:0] red_q [3];
  logic [cls_pkg::SampleBits-1:0] green_q [3];
  logic [cls_pkg::SampleBits-1:0] blue_q [3];

  logic [1:0]                     ri_d, gi_d, ri_q, gi_q;
  logic [cls_pkg::SampleBits-1:0] rpk_q, gpk_q;
  logic [cls_pkg::SumBits-1:0]    rsum_d, gsum_d, rsum_q, gsum_q;

  logic [cls_pkg::ProdBits-1:0] r_scaled, g_scaled, r_limit, g_limit;
  logic                         red_dom, green_dom, green_all;

  always_comb begin
    state_d = state_q;
    case (state_q)
      cls_pkg::FE_IDLE:  if (in_valid_i) state_d = cls_pkg::FE_PEAK;
      cls_pkg::FE_PEAK:  state_d = cls_pkg::FE_CLASS;
      cls_pkg::FE_CLASS: if (!full_i) state_d = cls_pkg::FE_IDLE;
      default:           state_d = cls_pkg::FE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cls_pkg::FE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == cls_pkg::FE_IDLE);

  // Capture the samples, low bits only
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      red_q[0]   <= in_data_i.right_red[cls_pkg::SampleBits-1:0];
      green_q[0] <= in_data_i.right_green[cls_pkg::SampleBits-1:0];
      blue_q[0]  <= in_data_i.right_blue[cls_pkg::SampleBits-1:0];
      red_q[1]   <= in_data_i.center_red[cls_pkg::SampleBits-1:0];
      green_q[1] <= in_data_i.center_green[cls_pkg::SampleBits-1:0];
      blue_q[1]  <= in_data_i.center_blue[cls_pkg::SampleBits-1:0];
      red_q[2]   <= in_data_i.left_red[cls_pkg::SampleBits-1:0];
      green_q[2] <= in_data_i.left_green[cls_pkg::SampleBits-1:0];
      blue_q[2]  <= in_data_i.left_blue[cls_pkg::SampleBits-1:0];
    end
  end

  // Peak search: strict greater, so the lower index wins a tie
  always_comb begin
    ri_d = cls_pkg::SensorRight;
    gi_d = cls_pkg::SensorRight;
    for (int i = 1; i < 3; i++) begin
      if (red_q[i] > red_q[ri_d])     ri_d = 2'(i);
      if (green_q[i] > green_q[gi_d]) gi_d = 2'(i);
    end
    rsum_d = cls_pkg::SumBits'(red_q[ri_d]) + cls_pkg::SumBits'(green_q[ri_d])
           + cls_pkg::SumBits'(blue_q[ri_d]);
    gsum_d = cls_pkg::SumBits'(red_q[gi_d]) + cls_pkg::SumBits'(green_q[gi_d])
           + cls_pkg::SumBits'(blue_q[gi_d]);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == cls_pkg::FE_PEAK) begin
      ri_q   <= ri_d;
      gi_q   <= gi_d;
      rpk_q  <= red_q[ri_d];
      gpk_q  <= green_q[gi_d];
      rsum_q <= rsum_d;
      gsum_q <= gsum_d;
    end
  end

  // floor(10 * peak / sum) >= sens  <=>  10 * peak >= sens * sum, sum nonzero
  always_comb begin
    r_scaled  = cls_pkg::ProdBits'(rpk_q) * cls_pkg::ProdBits'(cls_pkg::DomScale);
    g_scaled  = cls_pkg::ProdBits'(gpk_q) * cls_pkg::ProdBits'(cls_pkg::DomScale);
    r_limit   = cls_pkg::ProdBits'(rsum_q) * cls_pkg::ProdBits'(cfg_i.sensitivity);
    g_limit   = cls_pkg::ProdBits'(gsum_q) * cls_pkg::ProdBits'(cfg_i.sensitivity);
    red_dom   = (rsum_q != '0) && (r_scaled >= r_limit);
    green_dom = (gsum_q != '0) && (g_scaled >= g_limit);
    green_all = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (16'(green_q[i]) < cfg_i.green_threshold) green_all = 1'b0;
    end
  end

  assign push_o = (state_q == cls_pkg::FE_CLASS) && !full_i;

  always_comb begin
    push_data_o.red_idx    = ri_q;
    push_data_o.green_idx  = gi_q;
    push_data_o.red_peak   = rpk_q;
    push_data_o.green_peak = gpk_q;
    push_data_o.red_dom    = red_dom;
    push_data_o.green_dom  = green_dom;
    push_data_o.green_all  = green_all;
  end

endmodule

`default_nettype wire

// ===== rtl/cls_queue.sv =====
// Short queue of classified items between the front and the back.
// Depends on cls_pkg.
`default_nettype none

module cls_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire cls_pkg::cls_class_t push_data_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output cls_pkg::cls_class_t     head_o
);

  cls_pkg::cls_class_t mem_q [cls_pkg::QueueDepth];

  logic [cls_pkg::QueuePtrW-1:0] wr_q, rd_q;
  logic [cls_pkg::QueueCntW-1:0] cnt_q;

  function automatic logic [cls_pkg::QueuePtrW-1:0] ptr_inc(
      logic [cls_pkg::QueuePtrW-1:0] p);
    logic [cls_pkg::QueuePtrW-1:0] n;
    if (p == cls_pkg::QueuePtrW'(cls_pkg::QueueDepth - 1)) n = '0;
    else n = p + 1'b1;
    return n;
  endfunction

  assign full_o  = (cnt_q == cls_pkg::QueueCntW'(cls_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ptr_inc(wr_q);
      if (pop_i)  rd_q <= ptr_inc(rd_q);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cls_back.sv =====
// Back part: indicator latch with hold-down, steering mode FSM, output register.
// Depends on cls_pkg.
`default_nettype none

module cls_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cls_pkg::cls_cfg_t   cfg_i,
  input  wire logic               q_valid_i,
  input  wire cls_pkg::cls_class_t q_head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output cls_pkg::cls_out_t       out_data_o
);

  cls_pkg::cls_mode_e             mode_q, mode_d;
  logic [cls_pkg::SampleBits-1:0] peak_q, peak_d;
  logic [3:0]                     hold_q, hold_d, hold_dec;
  logic                           ind_q, ind_d;
  logic                           out_valid_q;
  cls_pkg::cls_out_t              out_q;
  cls_pkg::cls_track_t            trk;

  logic                           red_wins, green_wins;
  cls_pkg::cls_class_t            c;

  // Side of a peak sensor to its mode; a center peak maps to default
  function automatic cls_pkg::cls_mode_e side_mode(logic [1:0] idx,
      cls_pkg::cls_mode_e right_m, cls_pkg::cls_mode_e left_m);
    cls_pkg::cls_mode_e m;
    if (idx == cls_pkg::SensorLeft)       m = left_m;
    else if (idx == cls_pkg::SensorRight) m = right_m;
    else                                  m = cls_pkg::MODE_DEFAULT;
    return m;
  endfunction

  // Own color still leads: flip sides, track a center peak, or hold
  function automatic cls_pkg::cls_track_t own_color(
      logic [1:0] idx, logic [cls_pkg::SampleBits-1:0] pk, logic dom,
      logic [1:0] opp_idx, cls_pkg::cls_mode_e opp_mode,
      cls_pkg::cls_mode_e cur_mode, logic [cls_pkg::SampleBits-1:0] last);
    cls_pkg::cls_track_t t;
    t.mode      = cur_mode;
    t.last_peak = last;
    if (idx == opp_idx && dom) begin
      t.mode      = opp_mode;
      t.last_peak = '0;
    end else if (idx == cls_pkg::SensorCenter) begin
      if (pk <= last) begin
        t.mode      = cls_pkg::MODE_DEFAULT;
        t.last_peak = '0;
      end else begin
        t.last_peak = pk;
      end
    end
    return t;
  endfunction

  assign pop_o = q_valid_i && (!out_valid_q || out_ready_i);
  assign c     = q_head_i;

  assign green_wins = (c.green_peak >= c.red_peak);
  assign red_wins   = (c.red_peak >= c.green_peak);

  // Indicator: count down, then toggle and reload when all greens are high
  always_comb begin
    hold_dec = (hold_q != '0) ? hold_q - 4'd1 : hold_q;
    hold_d   = hold_dec;
    ind_d    = ind_q;
    if (hold_dec == '0 && c.green_all) begin
      ind_d  = ~ind_q;
      hold_d = cfg_i.hold_ticks;
    end
  end

  always_comb begin
    mode_d = mode_q;
    peak_d = peak_q;
    trk    = '{mode: mode_q, last_peak: peak_q};
    case (mode_q)
      cls_pkg::MODE_RG, cls_pkg::MODE_LG: begin
        if (green_wins) begin
          if (mode_q == cls_pkg::MODE_RG) begin
            trk = own_color(c.green_idx, c.green_peak, c.green_dom, cls_pkg::SensorLeft,
                            cls_pkg::MODE_LG, mode_q, peak_q);
          end else begin
            trk = own_color(c.green_idx, c.green_peak, c.green_dom, cls_pkg::SensorRight,
                            cls_pkg::MODE_RG, mode_q, peak_q);
          end
          mode_d = trk.mode;
          peak_d = trk.last_peak;
        end else if (c.red_dom) begin
          mode_d = side_mode(c.red_idx, cls_pkg::MODE_RR, cls_pkg::MODE_LR);
          peak_d = '0;
        end else begin
          mode_d = cls_pkg::MODE_DEFAULT;
          peak_d = '0;
        end
      end
      cls_pkg::MODE_RR, cls_pkg::MODE_LR: begin
        if (red_wins) begin
          if (mode_q == cls_pkg::MODE_RR) begin
            trk = own_color(c.red_idx, c.red_peak, c.red_dom, cls_pkg::SensorLeft,
                            cls_pkg::MODE_LR, mode_q, peak_q);
          end else begin
            trk = own_color(c.red_idx, c.red_peak, c.red_dom, cls_pkg::SensorRight,
                            cls_pkg::MODE_RR, mode_q, peak_q);
          end
          mode_d = trk.mode;
          peak_d = trk.last_peak;
        end else if (c.green_dom) begin
          mode_d = side_mode(c.green_idx, cls_pkg::MODE_RG, cls_pkg::MODE_LG);
          peak_d = '0;
        end else begin
          mode_d = cls_pkg::MODE_DEFAULT;
          peak_d = '0;
        end
      end
      default: begin
        if (green_wins && c.green_dom) begin
          mode_d = side_mode(c.green_idx, cls_pkg::MODE_RG, cls_pkg::MODE_LG);
        end else if (!green_wins && c.red_dom) begin
          mode_d = side_mode(c.red_idx, cls_pkg::MODE_RR, cls_pkg::MODE_LR);
        end else begin
          mode_d = cls_pkg::MODE_DEFAULT;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= cls_pkg::MODE_DEFAULT;
      peak_q      <= '0;
      hold_q      <= '0;
      ind_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        mode_q      <= mode_d;
        peak_q      <= peak_d;
        hold_q      <= hold_d;
        ind_q       <= ind_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q.motion     <= cls_pkg::motion_code(mode_d);
      out_q.steer_mode <= cls_pkg::mode_code(mode_d);
      out_q.indicator  <= ind_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/color_light_steering_fsm_unit.sv =====
// Top level of the color light steering block: configuration registers and
// the front, queue and back parts. Depends on cls_pkg, cls_front, cls_queue, cls_back.
//
// Usage:
//   in channel  : in_valid_i / in_ready_o carry one tick of nine RGB readings
//                 (right, center, left sensors) as a cls_in_t item.
//   out channel : out_valid_o / out_ready_i carry one result item per tick:
//                 motion command, new steering mode and indicator level.
//   cfg channel : cfg_valid_i / cfg_ready_o write sensitivity (index 0),
//                 green threshold (1) or hold ticks (2); other indexes are
//                 dropped. Write only while no item is in flight.
// Timing: the front takes a new item only after it has pushed the last one (capture,
//   peak search, dominance test); in_ready_o is low from the accept until that push.
//   When the output is free, an item passes the capture, peak, queue and output registers.
// Stall: a result waits in the output register while out_ready_i is low;
//   up to two classified items queue behind it, then the front holds its
//   item and in_ready_o stays low.
// Reset: mode default, last peak 0, hold count 0, indicator 0, config
//   registers back to 5 / 0x3200 / 6, queue and output register empty.
`default_nettype none

module color_light_steering_fsm_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire cls_pkg::cls_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output cls_pkg::cls_out_t      out_data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [15:0]       cfg_data_i
);

  cls_pkg::cls_cfg_t   cfg_q;
  logic                push, full, pop, q_valid;
  cls_pkg::cls_class_t push_data, q_head;

  // Config writes are always taken; truncate data to register width
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensitivity     <= cls_pkg::SensitivityReset;
      cfg_q.green_threshold <= cls_pkg::GreenThresholdReset;
      cfg_q.hold_ticks      <= cls_pkg::HoldTicksReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        cls_pkg::CfgSensitivity:    cfg_q.sensitivity     <= cfg_data_i[3:0];
        cls_pkg::CfgGreenThreshold: cfg_q.green_threshold <= cfg_data_i;
        cls_pkg::CfgHoldTicks:      cfg_q.hold_ticks      <= cfg_data_i[3:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Front: capture, peak search, dominance test
  cls_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // Decouple front and back so each can stall on its own
  cls_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // Back: indicator latch, steering FSM, output register
  cls_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/cls_checker.sv =====
// Port-level checker for color_light_steering_fsm_unit and its bind.
// Depends on cls_pkg.
`default_nettype none

module cls_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire cls_pkg::cls_out_t out_data_o
);

  // A pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // The front works on one item at a time
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item taken while front busy");

  // No result is pending in the first cycle out of reset
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result shown right after reset");

  // Steering mode is one of the five codes
  a_mode_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.steer_mode == cls_pkg::ModeCodeDefault ||
                     out_data_o.steer_mode == cls_pkg::ModeCodeRg ||
                     out_data_o.steer_mode == cls_pkg::ModeCodeLg ||
                     out_data_o.steer_mode == cls_pkg::ModeCodeLr ||
                     out_data_o.steer_mode == cls_pkg::ModeCodeRr))
    else $error("bad steering mode code");

  // Motion follows the mode's side
  a_motion: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (((out_data_o.steer_mode == cls_pkg::ModeCodeRg ||
         out_data_o.steer_mode == cls_pkg::ModeCodeRr) ==
        (out_data_o.motion == cls_pkg::MotionRight)) &&
       ((out_data_o.steer_mode == cls_pkg::ModeCodeLg ||
         out_data_o.steer_mode == cls_pkg::ModeCodeLr) ==
        (out_data_o.motion == cls_pkg::MotionLeft))))
    else $error("motion does not match steering mode");

endmodule

bind color_light_steering_fsm_unit cls_checker u_cls_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for color_light_steering_fsm_unit: drives sensor ticks over
// valid/ready, predicts motion, steering mode and indicator per tick, and checks each result.
// Depends on cls_pkg and the RTL of the block.
module tb;
  import cls_pkg::*;

  localparam int MaxCycles   = 400000;
  localparam int DrainCycles = 16;
  localparam int MaxReports  = 10;

  // Index that maps to no register; writes to it must be dropped
  localparam logic [1:0] CfgUnused = 2'd3;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  cls_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  cls_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  color_light_steering_fsm_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  // Ticks waiting to be driven and results still owed by the block
  cls_in_t  tick_q[$];
  cls_out_t steer_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int results_seen  = 0;
  int cycle_count   = 0;

  // Shadow of the configuration registers
  logic [3:0]  sens_cfg = SensitivityReset;
  logic [15:0] thr_cfg  = GreenThresholdReset;
  logic [3:0]  hold_cfg = HoldTicksReset;

  // Shadow of the steering and indicator state
  logic [2:0]  mode_q      = ModeCodeDefault;
  logic [15:0] last_peak_q = '0;
  logic [3:0]  hold_cnt_q  = '0;
  logic        ind_q       = 1'b0;

  // A color dominates when ten times its peak over the sensor sum reaches the
  // sensitivity; a zero sum never dominates.
  function automatic logic dominant(logic [15:0] peak, logic [17:0] sum);
    if (sum == '0) return 1'b0;
    return ((32'(peak) * 32'(DomScale)) / 32'(sum)) >= 32'(sens_cfg);
  endfunction

  // Mode that steers toward a side sensor; the center maps to default
  function automatic logic [2:0] side_mode(logic [1:0] idx, logic is_green);
    if (idx == SensorRight) return is_green ? ModeCodeRg : ModeCodeRr;
    if (idx == SensorLeft)  return is_green ? ModeCodeLg : ModeCodeLr;
    return ModeCodeDefault;
  endfunction

  // Own color still leads: jump to the opposite side, track a center peak
  // while it keeps rising, or hold the mode.
  function automatic void track_own(logic [1:0] idx, logic [15:0] peak, logic dom,
                                    logic [1:0] opp_idx, logic [2:0] opp_mode);
    if (idx == opp_idx && dom) begin
      mode_q      = opp_mode;
      last_peak_q = '0;
    end else if (idx == SensorCenter) begin
      if (peak <= last_peak_q) begin
        mode_q      = ModeCodeDefault;
        last_peak_q = '0;
      end else begin
        last_peak_q = peak;
      end
    end
  endfunction

  // Advance the shadow state by one tick and return the result it causes
  function automatic cls_out_t steer_predict(cls_in_t t);
    logic [15:0] r [3];
    logic [15:0] g [3];
    logic [15:0] b [3];
    logic [17:0] s [3];
    logic [1:0]  ri;
    logic [1:0]  gi;
    logic [15:0] rp;
    logic [15:0] gp;
    logic        dr;
    logic        dg;
    cls_out_t    o;
    r[0] = t.right_red;  g[0] = t.right_green;  b[0] = t.right_blue;
    r[1] = t.center_red; g[1] = t.center_green; b[1] = t.center_blue;
    r[2] = t.left_red;   g[2] = t.left_green;   b[2] = t.left_blue;
    ri = SensorRight;
    gi = SensorRight;
    for (int i = 0; i < 3; i++) begin
      s[i] = 18'(r[i]) + 18'(g[i]) + 18'(b[i]);
      if (r[i] > r[ri]) ri = 2'(i);
      if (g[i] > g[gi]) gi = 2'(i);
    end
    rp = r[ri];
    gp = g[gi];
    dr = dominant(rp, s[ri]);
    dg = dominant(gp, s[gi]);

    if (hold_cnt_q != '0) hold_cnt_q = hold_cnt_q - 4'd1;
    if (hold_cnt_q == '0 && g[0] >= thr_cfg && g[1] >= thr_cfg && g[2] >= thr_cfg) begin
      ind_q      = ~ind_q;
      hold_cnt_q = hold_cfg;
    end

    case (mode_q)
      ModeCodeRg, ModeCodeLg: begin
        if (gp >= rp) begin
          if (mode_q == ModeCodeRg) track_own(gi, gp, dg, SensorLeft, ModeCodeLg);
          else track_own(gi, gp, dg, SensorRight, ModeCodeRg);
        end else begin
          mode_q      = dr ? side_mode(ri, 1'b0) : ModeCodeDefault;
          last_peak_q = '0;
        end
      end
      ModeCodeRr, ModeCodeLr: begin
        if (rp >= gp) begin
          if (mode_q == ModeCodeRr) track_own(ri, rp, dr, SensorLeft, ModeCodeLr);
          else track_own(ri, rp, dr, SensorRight, ModeCodeRr);
        end else begin
          mode_q      = dg ? side_mode(gi, 1'b1) : ModeCodeDefault;
          last_peak_q = '0;
        end
      end
      default: begin
        // A center peak leaves the block in default mode
        if (gp >= rp && dg) mode_q = side_mode(gi, 1'b1);
        else if (rp > gp && dr) mode_q = side_mode(ri, 1'b0);
        else mode_q = ModeCodeDefault;
      end
    endcase

    case (mode_q)
      ModeCodeRg, ModeCodeRr: o.motion = MotionRight;
      ModeCodeLg, ModeCodeLr: o.motion = MotionLeft;
      default:                o.motion = MotionForward;
    endcase
    o.steer_mode = mode_q;
    o.indicator  = ind_q;
    return o;
  endfunction

  // Driver: present the next pending tick, predict on accept
  always @(posedge clk_i) begin : drive_ticks
    logic    next_valid;
    cls_in_t next_data;
    next_valid = in_valid;
    next_data  = in_data;
    if (in_valid && in_ready) begin
      steer_q.push_back(steer_predict(in_data));
      next_valid = 1'b0;
    end
    // Keep valid high across back-to-back items: one assignment per edge
    if (!next_valid && tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      next_data  = tick_q.pop_front();
      next_valid = 1'b1;
    end
    in_valid <= next_valid;
    in_data  <= next_data;
  end

  // Monitor: compare each accepted result against the oldest prediction
  always @(posedge clk_i) begin : check_results
    cls_out_t want;
    if (out_valid && out_ready) begin
      if (steer_q.size() == 0) begin
        if (mismatches < MaxReports)
          $display("result %0d: unexpected, got motion %0d mode %0d indicator %0d",
                   results_seen, out_data.motion, out_data.steer_mode, out_data.indicator);
        mismatches++;
      end else begin
        want = steer_q.pop_front();
        if (out_data.motion !== want.motion || out_data.steer_mode !== want.steer_mode ||
            out_data.indicator !== want.indicator) begin
          if (mismatches < MaxReports)
            $display("result %0d: expected motion %0d mode %0d indicator %0d, got %0d %0d %0d",
                     results_seen, want.motion, want.steer_mode, want.indicator,
                     out_data.motion, out_data.steer_mode, out_data.indicator);
          mismatches++;
        end
      end
      results_seen++;
    end
    out_ready <= (rst_ni && $urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: end a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= MaxCycles) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic cls_in_t mk(logic [15:0] rr, logic [15:0] rg, logic [15:0] rb,
                                 logic [15:0] cr, logic [15:0] cg, logic [15:0] cb,
                                 logic [15:0] lr, logic [15:0] lg, logic [15:0] lb);
    return {rr, rg, rb, cr, cg, cb, lr, lg, lb};
  endfunction

  function automatic logic [15:0] clamp16(int x);
    if (x < 0) return '0;
    if (x > 65535) return 16'hFFFF;
    return 16'(x);
  endfunction

  // One sensor carries a strong red or green reading over a low background
  function automatic cls_in_t strong_tick(logic is_green, int side, int mag);
    logic [15:0] v [9];
    int          shift;
    shift = $urandom_range(2, 12);
    for (int i = 0; i < 9; i++) v[i] = 16'($urandom_range(0, mag >> shift));
    // Clear the rest of the sensor now and then so full dominance is reachable
    if ($urandom_range(3) == 0) begin
      v[side * 3]     = '0;
      v[side * 3 + 1] = '0;
      v[side * 3 + 2] = '0;
    end
    v[side * 3 + (is_green ? 1 : 0)] = clamp16(mag);
    return mk(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
  endfunction

  // Four-bit register value with random bits above the field
  function automatic logic [15:0] nib(logic [3:0] v);
    return {12'($urandom), v};
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CfgSensitivity:    sens_cfg = value[3:0];
      CfgGreenThreshold: thr_cfg  = value;
      CfgHoldTicks:      hold_cfg = value[3:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Hold until every tick is in and every result is out, then let the block settle
  task automatic drain();
    while (tick_q.size() != 0 || in_valid || steer_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic gen_ticks(int n);
    int          remaining;
    int          kind;
    int          side;
    int          mag;
    int          steps;
    logic        is_green;
    logic [15:0] v [9];
    remaining = n;
    while (remaining > 0) begin
      kind = $urandom_range(99);
      if (kind < 50) begin
        // Steering sequence: side peak, rising center peaks, then a stop or a switch
        is_green = 1'($urandom_range(1));
        side     = $urandom_range(1) ? SensorLeft : SensorRight;
        mag      = $urandom_range(64, 60000);
        tick_q.push_back(strong_tick(is_green, side, mag));
        remaining--;
        steps = $urandom_range(4);
        for (int k = 0; k < steps; k++) begin
          mag = clamp16(mag + $urandom_range(1, 3000));
          tick_q.push_back(strong_tick(is_green, SensorCenter, mag));
          remaining--;
        end
        case ($urandom_range(3))
          0: tick_q.push_back(strong_tick(is_green, SensorCenter,
                                          clamp16(mag - $urandom_range(0, 2))));
          1: tick_q.push_back(strong_tick(is_green,
                                          (side == SensorLeft) ? SensorRight : SensorLeft,
                                          $urandom_range(64, 65535)));
          2: tick_q.push_back(strong_tick(!is_green, $urandom_range(2),
                                          $urandom_range(64, 65535)));
          default: remaining++;
        endcase
        remaining--;
      end else begin
        for (int i = 0; i < 9; i++) begin
          if (kind < 65) begin
            v[i] = 16'($urandom);
          end else if (kind < 75) begin
            v[i] = 16'($urandom_range(3));
          end else if (kind < 90) begin
            // Greens around the threshold, others scaled down
            if (i % 3 == 1) v[i] = clamp16(int'(thr_cfg) + $urandom_range(4) - 2);
            else v[i] = 16'($urandom) >> $urandom_range(15);
          end else begin
            case ($urandom_range(2))
              0:       v[i] = '0;
              1:       v[i] = 16'hFFFF;
              default: v[i] = 16'($urandom);
            endcase
          end
        end
        tick_q.push_back(mk(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]));
        remaining--;
      end
    end
  endtask

  initial begin
    send_idle_pct = 16;
    recv_idle_pct = 87;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed ticks under the reset configuration
    tick_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));                  // zero sums
    tick_q.push_back(mk('1, '1, '1, '1, '1, '1, '1, '1, '1));         // all max, toggle
    tick_q.push_back(mk(0, 4000, 0, 0, 100, 0, 0, 100, 0));           // right green
    tick_q.push_back(mk(0, 100, 0, 0, 100, 0, 0, 5000, 0));           // over to left green
    tick_q.push_back(mk(0, 5000, 0, 0, 100, 0, 0, 100, 0));           // back to right green
    tick_q.push_back(mk(0, 10, 0, 0, 1000, 0, 0, 10, 0));             // center peak, track
    tick_q.push_back(mk(0, 10, 0, 0, 2000, 0, 0, 10, 0));             // center rising
    tick_q.push_back(mk(0, 10, 0, 0, 2000, 0, 0, 10, 0));             // stops rising
    tick_q.push_back(mk(3000, 0, 0, 0, 0, 0, 0, 0, 0));               // right red
    tick_q.push_back(mk(0, 0, 0, 0, 0, 0, 3000, 0, 0));               // over to left red
    tick_q.push_back(mk(10, 3000, 0, 10, 0, 0, 10, 0, 0));            // left red, green right
    tick_q.push_back(mk(0, 0, 0, 0, 0, 0, 3000, 0, 0));               // red from green mode
    tick_q.push_back(mk(0, 0, 0, 0, 0, 0, 10, 3000, 0));              // left red to left green
    tick_q.push_back(mk(100, 100, 100, 100, 100, 100, 100, 100, 100)); // ties, hold
    tick_q.push_back(mk(0, 0, 0, 3000, 0, 0, 0, 0, 0));               // center red leaves
    tick_q.push_back(mk(0, 0, 0, 0, 3000, 0, 0, 0, 0));               // center in default
    tick_q.push_back(mk(500, 0, 500, 0, 0, 0, 0, 0, 0));              // ratio at the bound
    tick_q.push_back(mk(4000, 0, 0, 0, 0, 0, 4000, 0, 0));            // red tie, low index
    tick_q.push_back(mk(0, 100, 200, 0, 0, 0, 0, 0, 0));              // weak green, default
    tick_q.push_back(mk(499, 0, 501, 0, 0, 0, 0, 0, 0));              // just below the bound
    tick_q.push_back(mk('1, 0, '1, 0, 0, 0, 0, 0, 0));                // full blue in sum
    tick_q.push_back(mk(0, thr_cfg, 0, 0, thr_cfg, 0, 0, thr_cfg, 0)); // greens at threshold
    tick_q.push_back(mk(0, thr_cfg, 0, 0, thr_cfg, 0, 0, thr_cfg, 0)); // locked out
    tick_q.push_back(mk(0, thr_cfg, 0, 0, thr_cfg - 16'd1, 0, 0, thr_cfg, 0)); // one short
    drain();

    // Zero sensitivity, zero threshold, no lock-out
    write_reg(CfgSensitivity, nib(4'd0));
    write_reg(CfgGreenThreshold, 16'h0000);
    write_reg(CfgHoldTicks, nib(4'd0));
    gen_ticks(250);
    drain();

    write_reg(CfgSensitivity, nib(4'd5));
    write_reg(CfgGreenThreshold, 16'($urandom_range(8000, 20000)));
    write_reg(CfgHoldTicks, nib(4'd15));
    gen_ticks(230);
    drain();

    // Swap the idle pattern: bursty sender, eager receiver
    send_idle_pct = 87;
    recv_idle_pct = 16;
    write_reg(CfgSensitivity, nib(4'd10));
    write_reg(CfgGreenThreshold, 16'hFFFF);
    write_reg(CfgHoldTicks, nib(4'd1));
    write_reg(CfgUnused, 16'($urandom));
    gen_ticks(240);
    drain();

    // Sensitivity above ten: nothing dominates
    write_reg(CfgSensitivity, nib(4'd15));
    write_reg(CfgGreenThreshold, 16'($urandom));
    write_reg(CfgHoldTicks, nib(4'($urandom_range(1, 15))));
    gen_ticks(240);
    drain();

    // Full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CfgSensitivity, nib(4'($urandom_range(1, 9))));
    write_reg(CfgGreenThreshold, GreenThresholdReset);
    write_reg(CfgHoldTicks, nib(HoldTicksReset));
    gen_ticks(250);
    drain();

    write_reg(CfgSensitivity, nib(4'($urandom)));
    write_reg(CfgGreenThreshold, 16'($urandom_range(0, 30000)));
    write_reg(CfgHoldTicks, nib(4'($urandom)));
    gen_ticks(240);
    drain();

    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== color_light_steering_fsm_unit.f =====
rtl/cls_pkg.sv
rtl/cls_front.sv
rtl/cls_queue.sv
rtl/cls_back.sv
rtl/color_light_steering_fsm_unit.sv
rtl/cls_checker.sv
dv/tb.sv
